// ===== hdl/skrs_pkg.sv =====
// skrs_pkg: shared types and constants for the sorted key route selector
// used by skrs_cell, sorted_key_route_selector and skrs_checker; no dependencies
package skrs_pkg;

    // field widths of the stream beats
    localparam int KEY_W   = 64;
    localparam int LOC_W   = 32;
    localparam int PRIOR_W = 5;
    localparam int ROUTE_W = 4;
    localparam int CMD_W   = 2;

    // slave tdata layout: key, location, prior_route, padded to whole bytes
    localparam int S_KEY_LSB   = 0;
    localparam int S_LOC_LSB   = S_KEY_LSB + KEY_W;
    localparam int S_PRIOR_LSB = S_LOC_LSB + LOC_W;
    localparam int S_TDATA_W   = ((S_PRIOR_LSB + PRIOR_W + 7) / 8) * 8;

    // slave tuser layout: command, has_key
    localparam int S_CMD_LSB  = 0;
    localparam int S_HAS_BIT  = S_CMD_LSB + CMD_W;
    localparam int S_TUSER_W  = S_HAS_BIT + 1;

    // master tdata layout: route_index, next_hop, padded to whole bytes
    localparam int M_IDX_LSB = 0;
    localparam int M_HOP_LSB = M_IDX_LSB + ROUTE_W;
    localparam int M_TDATA_W = ((M_HOP_LSB + LOC_W + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_LSB = 3;
    localparam logic REG_NODE_ID = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_RETRY  = 2'd2
    } t_cmd;

    // how a cell decides whether it is the chosen route
    typedef enum logic {
        SEL_BOUNDARY = 1'b0,
        SEL_INDEX    = 1'b1
    } t_sel_mode;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             ins;
        t_sel_mode        mode;
        logic [KEY_W-1:0] key;
        logic [LOC_W-1:0] loc;
    } t_cell_ctl;

endpackage

// ===== hdl/sorted_key_route_selector.sv =====
// sorted_key_route_selector: sorted route table with greedy and retry lookup
// depends on skrs_pkg and skrs_cell
// a lookup beat shows its result in the cycle after acceptance
// throughput: one beat per cycle while the master side is not stalling; an add shifts the whole row of cells at once
// the result register frees the input side whenever it is empty or being taken
// reset (synchronous, active low) clears the fill count, node_id and out valid
// table contents are not cleared; only slots below the fill count are read
module sorted_key_route_selector import skrs_pkg::*; #(
    parameter int MAX_ROUTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key[63:0], location[95:64], prior_route[100:96], zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0], has_key[2]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // route_index[3:0], next_hop[35:4], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // to_network[0]
    output logic                  m_axis_tuser,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_ROUTES);
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);
    localparam int CMP_W = (CNT_W > PRIOR_W) ? CNT_W : PRIOR_W;
    localparam int ENC_W = (IDX_W > ROUTE_W) ? IDX_W : ROUTE_W;

    logic [KEY_W-1:0]      r_node_id, n_node_id;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic                  r_to_net;
    logic [ROUTE_W-1:0]    r_idx;
    logic [LOC_W-1:0]      r_hop;

    t_cmd                  cmd;
    logic                  has_key;
    logic [KEY_W-1:0]      in_key;
    logic [LOC_W-1:0]      in_loc;
    logic [PRIOR_W-1:0]    in_prior;
    logic                  s_beat;
    logic                  is_lookup;
    logic signed [PRIOR_W:0] try_idx;
    logic [CMP_W-1:0]      try_ext;
    logic [CNT_W-1:0]      last_cnt;
    logic                  use_prior;
    logic                  onward;
    t_cell_ctl             ctl;
    logic [IDX_W-1:0]      sel_idx;

    logic [MAX_ROUTES-1:0] c_gt, c_ge, c_sel;
    logic [KEY_W-1:0]      c_key [MAX_ROUTES];
    logic [LOC_W-1:0]      c_loc [MAX_ROUTES];
    logic [LOC_W-1:0]      pick_loc;
    logic [ENC_W-1:0]      pick_idx;

    // unpack the slave beat
    assign cmd      = t_cmd'(s_axis_tuser[S_CMD_LSB +: CMD_W]);
    assign has_key  = s_axis_tuser[S_HAS_BIT];
    assign in_key   = s_axis_tdata[S_KEY_LSB +: KEY_W];
    assign in_loc   = s_axis_tdata[S_LOC_LSB +: LOC_W];
    assign in_prior = s_axis_tdata[S_PRIOR_LSB +: PRIOR_W];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign is_lookup     = (cmd == CMD_LOOKUP) || (cmd == CMD_RETRY);

    // retry index is prior_route minus one, used only when inside the table
    assign try_idx   = $signed({in_prior[PRIOR_W-1], in_prior}) - 6'sd1;
    assign try_ext   = CMP_W'(try_idx[PRIOR_W-1:0]);
    assign last_cnt  = r_count - 1'b1;
    assign use_prior = (cmd == CMD_RETRY) && !try_idx[PRIOR_W]
                       && (try_ext < CMP_W'(r_count));

    // broadcast to the cells; a key below the first entry picks the last one
    always_comb begin
        ctl.ins  = s_beat && (cmd == CMD_ADD) && (r_count != CNT_W'(MAX_ROUTES));
        ctl.mode = (!use_prior && c_ge[0]) ? SEL_BOUNDARY : SEL_INDEX;
        ctl.key  = in_key;
        ctl.loc  = in_loc;
        sel_idx  = use_prior ? try_ext[IDX_W-1:0] : last_cnt[IDX_W-1:0];
    end

    // row of table cells, each handing its entry to the right on insert
    for (genvar g = 0; g < MAX_ROUTES; g++) begin : g_cell
        logic             left_gt;
        logic [KEY_W-1:0] left_key;
        logic [LOC_W-1:0] left_loc;
        logic             right_ge;

        if (g == 0) begin : g_head
            assign left_gt  = 1'b1;
            assign left_key = '0;
            assign left_loc = '0;
        end else begin : g_body
            assign left_gt  = c_gt[g-1];
            assign left_key = c_key[g-1];
            assign left_loc = c_loc[g-1];
        end

        if (g == MAX_ROUTES - 1) begin : g_tail
            assign right_ge = 1'b0;
        end else begin : g_next
            assign right_ge = c_ge[g+1];
        end

        skrs_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_sel_idx  (sel_idx),
            .i_left_gt  (left_gt),
            .i_left_key (left_key),
            .i_left_loc (left_loc),
            .i_right_ge (right_ge),
            .o_gt       (c_gt[g]),
            .o_ge       (c_ge[g]),
            .o_sel      (c_sel[g]),
            .o_key      (c_key[g]),
            .o_loc      (c_loc[g])
        );
    end

    // one-hot select of the chosen cell
    always_comb begin
        pick_loc = '0;
        pick_idx = '0;
        for (int i = 0; i < MAX_ROUTES; i++) begin
            pick_loc = pick_loc | (c_sel[i] ? c_loc[i] : '0);
            pick_idx = pick_idx | (c_sel[i] ? ENC_W'(i) : '0);
        end
    end

    assign onward = has_key && (in_key != r_node_id) && (r_count != '0);

    // control next state
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_node_id   = r_node_id;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end
        if (s_beat && is_lookup) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (psel && penable && pwrite && pready
            && (paddr[REG_IDX_LSB] == REG_NODE_ID)) begin
            n_node_id = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_node_id   <= '0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_node_id   <= n_node_id;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_beat && is_lookup) begin
            r_to_net <= onward;
            r_idx    <= onward ? pick_idx[ROUTE_W-1:0] : '0;
            r_hop    <= onward ? pick_loc : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_to_net;
    assign m_axis_tdata  = M_TDATA_W'({r_hop, r_idx});

    // register read
    assign pready = 1'b1;
    assign prdata = (paddr[REG_IDX_LSB] == REG_NODE_ID) ? r_node_id : '0;

endmodule

// ===== hdl/skrs_cell.sv =====
// skrs_cell: one slot of the sorted route table, holding a key and a location
// depends on skrs_pkg; instantiated in a row by sorted_key_route_selector
module skrs_cell import skrs_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [IDX_W-1:0] i_sel_idx,
    input  logic             i_left_gt,
    input  logic [KEY_W-1:0] i_left_key,
    input  logic [LOC_W-1:0] i_left_loc,
    input  logic             i_right_ge,
    output logic             o_gt,
    output logic             o_ge,
    output logic             o_sel,
    output logic [KEY_W-1:0] o_key,
    output logic [LOC_W-1:0] o_loc
);

    logic [KEY_W-1:0] r_key, n_key;
    logic [LOC_W-1:0] r_loc, n_loc;
    logic             occ;
    logic             take_new;
    logic             shift;

    // slot holds a route when it lies below the fill count
    assign occ  = CNT_W'(IDX) < i_count;
    assign o_gt = occ && (i_ctl.key > r_key);
    assign o_ge = occ && (i_ctl.key >= r_key);

    // insert point is the first slot whose key is not smaller
    assign take_new = !o_gt && i_left_gt;
    assign shift    = !o_gt && !i_left_gt;

    always_comb begin
        n_key = r_key;
        n_loc = r_loc;
        if (i_ctl.ins && take_new) begin
            n_key = i_ctl.key;
            n_loc = i_ctl.loc;
        end else if (i_ctl.ins && shift) begin
            n_key = i_left_key;
            n_loc = i_left_loc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_loc <= n_loc;
    end

    // last slot not above the key, or the slot named by index
    always_comb begin
        case (i_ctl.mode)
            SEL_BOUNDARY: o_sel = o_ge && !i_right_ge;
            SEL_INDEX:    o_sel = (i_sel_idx == IDX_W'(IDX));
            default:      o_sel = 1'b0;
        endcase
    end

    assign o_key = r_key;
    assign o_loc = r_loc;

endmodule

// ===== hdl/skrs_checker.sv =====
// skrs_checker: port-level checks of sorted_key_route_selector over time
// depends on skrs_pkg; bound to the top level below
module skrs_checker import skrs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TUSER_W-1:0]  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tuser
);

    logic s_beat;
    logic s_lookup;

    assign s_beat   = s_axis_tvalid && s_axis_tready;
    assign s_lookup = (s_axis_tuser[S_CMD_LSB +: CMD_W] == CMD_LOOKUP)
                      || (s_axis_tuser[S_CMD_LSB +: CMD_W] == CMD_RETRY);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // every lookup beat yields a result in the next cycle
    a_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && s_lookup |=> m_axis_tvalid)
        else $error("lookup beat gave no result");

    // local delivery carries zero index and hop
    a_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("local delivery with nonzero payload");

    // input side is free whenever the result register is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track the result register");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_key_route_selector skrs_checker u_skrs_checker (.*);
